// ----- sv/pilot_carrier_pll_unit_defines.svh -----
// assertion macros for the pilot carrier pll unit
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef PILOT_CARRIER_PLL_UNIT_DEFINES_SVH
`define PILOT_CARRIER_PLL_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCPLL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PCPLL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pcpll_pkg.sv -----
// shared types and constants for the pilot carrier pll
// no dependencies; used by pcpll_cordic and pilot_carrier_pll_unit
package pcpll_pkg;

  // cordic datapath widths
  localparam int CORDIC_W   = 52;
  localparam int ZW         = 33;
  localparam int TABLE_LEN  = 24;
  localparam int ATAN_IDX_W = 5;

  // shared multiplier widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  // arctangent of 2^-i in q0.32 turns
  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // loop gain constants 2.666 and 3.555 in q16, cordic gain compensation in q2.30
  localparam logic signed [MUL_W-1:0]    CP_Q16          = 33'sd174719;
  localparam logic signed [MUL_W-1:0]    CI_Q16          = 33'sd232980;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 52'sd652032874;

  // register reset values
  localparam logic [31:0] PHASE_STEP_RST = 32'd340018244;
  localparam logic [15:0] NORM_BW_RST    = 16'd655;
  localparam logic [2:0]  NCO_SCALE_RST  = 3'd2;
  localparam logic [31:0] PHASE_ADJ_RST  = 32'd0;

  // register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_NORM_BW    = 2'd1,
    REG_NCO_SCALE  = 2'd2,
    REG_PHASE_ADJ  = 2'd3
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0_0000_0000_0001,
    ST_MUL_I   = 13'b0_0000_0000_0010,
    ST_MUL_Q   = 13'b0_0000_0000_0100,
    ST_VEC_LD  = 13'b0_0000_0000_1000,
    ST_VEC     = 13'b0_0000_0001_0000,
    ST_LOOP_I  = 13'b0_0000_0010_0000,
    ST_LOOP_P  = 13'b0_0000_0100_0000,
    ST_PHASE   = 13'b0_0000_1000_0000,
    ST_ARG     = 13'b0_0001_0000_0000,
    ST_ROT_FB  = 13'b0_0010_0000_0000,
    ST_FB      = 13'b0_0100_0000_0000,
    ST_ROT_OUT = 13'b0_1000_0000_0000,
    ST_OUT     = 13'b1_0000_0000_0000
  } state_e;

  // control word for the shared cordic stage
  typedef struct packed {
    logic load;
    logic step;
    logic vec;
  } cordic_ctrl_t;

endpackage

// ----- sv/pcpll_cordic.sv -----
// shared cordic micro-rotation stage, vectoring and rotation modes
// depends on pcpll_pkg; one iteration per cycle when stepped
module pcpll_cordic (
  input  logic                                  clk_i,
  input  pcpll_pkg::cordic_ctrl_t               ctrl_i,
  input  logic [pcpll_pkg::ATAN_IDX_W-1:0]      idx_i,
  input  logic signed [pcpll_pkg::CORDIC_W-1:0] x_ld_i,
  input  logic signed [pcpll_pkg::CORDIC_W-1:0] y_ld_i,
  input  logic [pcpll_pkg::ZW-1:0]              z_ld_i,
  output logic signed [pcpll_pkg::CORDIC_W-1:0] x_o,
  output logic signed [pcpll_pkg::CORDIC_W-1:0] y_o,
  output logic [pcpll_pkg::ZW-1:0]              z_o
);
  import pcpll_pkg::*;

  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, x_sh, y_sh;
  logic [ZW-1:0]              z_q, z_d, atan;
  logic                       up;

  // one micro-rotation; direction from y sign (vectoring) or z sign (rotation)
  always_comb begin
    x_sh = x_q >>> idx_i;
    y_sh = y_q >>> idx_i;
    atan = {1'b0, ATAN_TURNS[idx_i]};
    up   = ctrl_i.vec ? y_q[CORDIC_W-1] : ~z_q[ZW-1];
    x_d  = x_q;
    y_d  = y_q;
    z_d  = z_q;
    if (ctrl_i.load) begin
      x_d = x_ld_i;
      y_d = y_ld_i;
      z_d = z_ld_i;
    end else if (ctrl_i.step) begin
      if (up) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - atan;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + atan;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- sv/pilot_carrier_pll_unit.sv -----
// pilot carrier pll: phase detector, pi loop filter, nco and carrier output
// depends on pcpll_pkg, pcpll_cordic and pilot_carrier_pll_unit_defines.svh
// one word at a time: a new word is accepted only in idle, once the previous result has been
// loaded into the output register; this is set by the single cordic stage
//   that runs three passes per sample (vectoring, feedback rotation, output rotation)
// reset: async active low; registers to defaults, loop phases zero, feedback cos at one
`include "pilot_carrier_pll_unit_defines.svh"

module pilot_carrier_pll_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int PHASE_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // sample word in
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,  // [sample]
  // carrier word out
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata_o,  // [nco_out]
  // register write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [1:0]                              cfg_addr_i,
  input  logic [31:0]                             cfg_data_i
);
  import pcpll_pkg::*;

  localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SW      = SAMPLE_WIDTH;
  localparam int PW      = PHASE_WIDTH;
  localparam int NORM_SH = 48 - 2 * SAMPLE_WIDTH;
  localparam int CNT_W   = $clog2(CORDIC_STEPS);
  localparam int DLT_LO  = 62 - PHASE_WIDTH;
  localparam int Q_SH    = 31 - SAMPLE_WIDTH;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic signed [CORDIC_W-1:0] Q_RND =
    CORDIC_W'(64'd1 << (30 - SAMPLE_WIDTH));
  localparam logic signed [CORDIC_W-1:0] Q_MAX =
    CORDIC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic signed [CORDIC_W-1:0] Q_MIN = -Q_MAX - CORDIC_W'(1);
  localparam logic signed [SW-1:0] FB_ONE = {1'b0, {(SW-1){1'b1}}};

  // 32-bit register phase aligned to PW bits
  function automatic logic [PW-1:0] from_reg32(input logic [31:0] r);
    logic [47:0] w;
    w = {r, 16'b0};
    return w[47 -: PW];
  endfunction

  // PW-bit phase to q0.32 turns
  function automatic logic [31:0] to_turn32(input logic [PW-1:0] p);
    logic [PW+15:0] w;
    w = {p, 16'b0};
    return w[PW+15 -: 32];
  endfunction

  // q2.30 to rounded, saturated sample
  function automatic logic signed [SW-1:0] quantize(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] t;
    t = (v + Q_RND) >>> Q_SH;
    if (t > Q_MAX) t = Q_MAX;
    if (t < Q_MIN) t = Q_MIN;
    return t[SW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [31:0] step_q, adj_q;
  logic [15:0] bw_q;
  logic [2:0]  scale_q;

  logic signed [SW-1:0]       smp_q, fc_q, fs_q;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [CORDIC_W-1:0] ei_q, e_w, eq_w;
  logic                       zero_q, neg_q, fold;
  logic [31:0]                bwsq_q, kp_q, ki_q, err32, turn_w, turn_f;
  logic [PW-1:0]              integ_q, est_q, osc_q, arg_q, outp_q, arg_w;
  logic                       out_valid_q, out_load;
  logic signed [SW-1:0]       out_q;

  cordic_ctrl_t               cctrl;
  logic signed [CORDIC_W-1:0] cx, cy, cx_sel, cy_sel, x_ld, y_ld;
  logic [ZW-1:0]              cz, z_ld;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'($unsigned(out_q));

  // phase error from vectoring angle, zero for a zero product
  assign err32 = zero_q ? 32'd0 : cz[31:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_I: begin
        mul_a = MUL_W'(smp_q);
        mul_b = MUL_W'(fc_q);
      end
      ST_MUL_Q: begin
        mul_a = MUL_W'(smp_q);
        mul_b = MUL_W'(fs_q);
      end
      ST_VEC: begin
        if (cnt_q == CNT_W'(0)) begin
          mul_a = signed'({17'b0, bw_q});
          mul_b = signed'({17'b0, bw_q});
        end else if (cnt_q == CNT_W'(1)) begin
          mul_a = signed'({17'b0, bw_q});
          mul_b = CP_Q16;
        end else if (cnt_q == CNT_W'(2)) begin
          mul_a = signed'({1'b0, bwsq_q});
          mul_b = CI_Q16;
        end
      end
      ST_LOOP_I: begin
        mul_a = signed'({1'b0, ki_q});
        mul_b = MUL_W'(signed'(err32));
      end
      ST_LOOP_P: begin
        mul_a = signed'({1'b0, kp_q});
        mul_b = MUL_W'(signed'(err32));
      end
      default: ;
    endcase
  end

  // detector products scaled to 48 bits
  assign e_w  = CORDIC_W'(signed'(prod_q[2*SW-1:0])) <<< NORM_SH;
  assign eq_w = -e_w;

  // loop phase and rotation fold into the right half plane
  assign arg_w  = osc_q + est_q;
  assign turn_w = (state_q == ST_FB) ? to_turn32(outp_q) : to_turn32(arg_w);
  assign fold   = turn_w[31] ^ turn_w[30];
  assign turn_f = fold ? {~turn_w[31], turn_w[30:0]} : turn_w;

  // cordic load values and control
  always_comb begin
    if (state_q == ST_VEC_LD) begin
      x_ld = ei_q[CORDIC_W-1] ? -ei_q : ei_q;
      y_ld = ei_q[CORDIC_W-1] ? -eq_w : eq_w;
      z_ld = ei_q[CORDIC_W-1] ? {1'b0, 32'h8000_0000} : '0;
    end else begin
      x_ld = CORDIC_GAIN_INV;
      y_ld = '0;
      z_ld = ZW'(signed'(turn_f));
    end
    cctrl.load = (state_q == ST_VEC_LD) || (state_q == ST_ARG) || (state_q == ST_FB);
    cctrl.step = (state_q == ST_VEC) || (state_q == ST_ROT_FB) || (state_q == ST_ROT_OUT);
    cctrl.vec  = (state_q == ST_VEC);
  end

  pcpll_cordic u_cordic (
    .clk_i  (clk_i),
    .ctrl_i (cctrl),
    .idx_i  (ATAN_IDX_W'(cnt_q)),
    .x_ld_i (x_ld),
    .y_ld_i (y_ld),
    .z_ld_i (z_ld),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz)
  );

  // undo the half-turn fold
  assign cx_sel = neg_q ? -cx : cx;
  assign cy_sel = neg_q ? -cy : cy;

  assign out_load = (state_q == ST_OUT);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_MUL_Q;
      ST_MUL_Q:  state_d = ST_VEC_LD;
      ST_VEC_LD: state_d = ST_VEC;
      ST_VEC: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_LOOP_I;
        end
      end
      ST_LOOP_I: state_d = ST_LOOP_P;
      ST_LOOP_P: state_d = ST_PHASE;
      ST_PHASE:  state_d = ST_ARG;
      ST_ARG:    state_d = ST_ROT_FB;
      ST_ROT_FB: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_FB;
        end
      end
      ST_FB:     state_d = ST_ROT_OUT;
      ST_ROT_OUT: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end
      end
      // finished rotation waits until the output register is free
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // control, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= PHASE_STEP_RST;
      bw_q        <= NORM_BW_RST;
      scale_q     <= NCO_SCALE_RST;
      adj_q       <= PHASE_ADJ_RST;
      integ_q     <= '0;
      est_q       <= '0;
      osc_q       <= '0;
      fc_q        <= FB_ONE;
      fs_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_PHASE_STEP: step_q  <= cfg_data_i;
          REG_NORM_BW:    bw_q    <= cfg_data_i[15:0];
          REG_NCO_SCALE:  scale_q <= cfg_data_i[2:0];
          REG_PHASE_ADJ:  adj_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_LOOP_P) begin
        integ_q <= integ_q + prod_q[DLT_LO +: PW];
      end
      if (state_q == ST_PHASE) begin
        est_q <= est_q + prod_q[DLT_LO +: PW] + integ_q;
        osc_q <= osc_q + from_reg32(step_q);
      end
      if (state_q == ST_FB) begin
        fc_q <= quantize(cx_sel);
        fs_q <= quantize(cy_sel);
      end
      if (out_load && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      smp_q <= s_axis_tdata_i[SW-1:0];
    end
    if (state_q == ST_MUL_Q) begin
      ei_q <= e_w;
    end
    if (state_q == ST_VEC_LD) begin
      zero_q <= (ei_q == '0) && (eq_w == '0);
    end
    // loop gains from the bandwidth register
    if (state_q == ST_VEC) begin
      if (cnt_q == CNT_W'(1)) bwsq_q <= prod_q[31:0];
      if (cnt_q == CNT_W'(2)) kp_q   <= prod_q[33:2];
      if (cnt_q == CNT_W'(3)) ki_q   <= prod_q[49:18];
    end
    if (state_q == ST_ARG) begin
      arg_q <= arg_w;
    end
    if ((state_q == ST_ARG) || (state_q == ST_FB)) begin
      neg_q <= fold;
    end
    // output phase: scale times loop phase plus offset
    if (state_q == ST_ROT_FB) begin
      outp_q <= (arg_q & {PW{scale_q[0]}}) + ((arg_q << 1) & {PW{scale_q[1]}})
              + ((arg_q << 2) & {PW{scale_q[2]}}) + from_reg32(adj_q);
    end
    if (out_load && (!out_valid_q || m_axis_tready_i)) begin
      out_q <= quantize(cx_sel);
    end
  end

  // checks
  `PCPLL_ASSERT_NEXT(a_accept_starts, s_axis_tvalid_i && s_axis_tready_o, state_q == ST_MUL_I, "accepted word did not start the sequence")
  `PCPLL_ASSERT_NEXT(a_vec_done, state_q == ST_VEC && cnt_q == CNT_LAST, state_q == ST_LOOP_I && cnt_q == '0, "vectoring pass did not hand over to the loop filter")
  `PCPLL_ASSERT_IMPL(a_result_source, $rose(m_axis_tvalid_o), $past(state_q) == ST_OUT, "result raised outside the output stage")
  `PCPLL_ASSERT_IMPL(a_idle_cnt, state_q == ST_IDLE, cnt_q == '0, "step counter not cleared in idle")

endmodule
